// ===== src/melg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melg_pkg
// Shared types, constants and helpers for the MELG19937-64 generator.
// ----------------------------------------------------------------------------
package melg_pkg;

    localparam int RING_LEN      = 311;
    localparam int IDX_W         = 9;
    localparam int WORD_W        = 64;
    localparam int FAR_OFFSET    = 81;
    localparam int TEMPER_OFFSET = 19;
    localparam int LAG_SHIFT_L   = 23;
    localparam int LAG_SHIFT_R   = 33;
    localparam int TEMPER_SHIFT  = 16;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;

    localparam t_idx  LAST_POS    = t_idx'(RING_LEN - 1);
    localparam t_idx  LAG_INDEX   = t_idx'(RING_LEN);
    localparam t_word UPPER_BITS  = 64'hffff_fffe_0000_0000;
    localparam t_word LOWER_BITS  = 64'h0000_0001_ffff_ffff;
    localparam t_word TEMPER_MASK = 64'h6aed_e6fd_97b3_38ec;
    localparam t_word TWIST_RESET = 64'h5c32_e06d_f730_fc42;

    typedef enum logic [1:0] {
        REQ_GENERATE = 2'd0,
        REQ_WRITE    = 2'd1,
        REQ_POSITION = 2'd2
    } t_req;

    typedef struct packed {
        logic  gen;
        logic  rotate;
        logic  wr_en;
        t_idx  wr_offset;
        t_word wr_data;
        t_word new_word;
    } t_ring_ctrl;

    typedef struct packed {
        t_word tap_p;
        t_word tap_q;
        t_word tap_far;
        t_word tap_temper;
    } t_ring_taps;

    // Distance from the current position to an index, both below RING_LEN.
    function automatic t_idx ring_offset(input t_idx idx, input t_idx pos);
        logic [IDX_W:0] diff;
        diff = {1'b0, idx} - {1'b0, pos};
        if (diff[IDX_W]) begin
            diff = diff + (IDX_W+1)'(RING_LEN);
        end
        return diff[IDX_W-1:0];
    endfunction

endpackage

// ===== src/melg_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melg_cell
// One ring word; loads its neighbor on a shift or a direct write otherwise.
// ----------------------------------------------------------------------------
module melg_cell (
    input  logic                i_clk,
    input  logic                i_shift,
    input  melg_pkg::t_word     i_shift_data,
    input  logic                i_wr,
    input  melg_pkg::t_word     i_wr_data,
    output melg_pkg::t_word     o_word
);

    melg_pkg::t_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_shift_data;
        end else if (i_wr) begin
            r_word <= i_wr_data;
        end
    end

    assign o_word = r_word;

endmodule

// ===== src/melg_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melg_ring
// Chain of ring cells; cell k holds the word k places ahead of the position.
// ----------------------------------------------------------------------------
module melg_ring (
    input  logic                  i_clk,
    input  melg_pkg::t_ring_ctrl  i_ctrl,
    output melg_pkg::t_ring_taps  o_taps
);

    melg_pkg::t_word w_cell [melg_pkg::RING_LEN];
    melg_pkg::t_word w_tail_in;
    logic            w_shift;

    assign w_shift   = i_ctrl.gen | i_ctrl.rotate;
    assign w_tail_in = i_ctrl.rotate ? w_cell[0] : i_ctrl.new_word;

    for (genvar k = 0; k < melg_pkg::RING_LEN; k++) begin : g_cell
        localparam melg_pkg::t_idx K = melg_pkg::t_idx'(k);
        melg_pkg::t_word w_next;
        if (k == melg_pkg::RING_LEN - 1) begin : g_tail
            assign w_next = w_tail_in;
        end else begin : g_body
            assign w_next = w_cell[k+1];
        end
        melg_cell u_cell (
            .i_clk        (i_clk),
            .i_shift      (w_shift),
            .i_shift_data (w_next),
            .i_wr         (i_ctrl.wr_en && (i_ctrl.wr_offset == K)),
            .i_wr_data    (i_ctrl.wr_data),
            .o_word       (w_cell[k])
        );
    end

    assign o_taps.tap_p      = w_cell[0];
    assign o_taps.tap_q      = w_cell[1];
    assign o_taps.tap_far    = w_cell[melg_pkg::FAR_OFFSET];
    assign o_taps.tap_temper = w_cell[melg_pkg::TEMPER_OFFSET];

endmodule

// ===== src/melg_random_generator_64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melg_random_generator_64
// MELG19937-64 generator built on a rotating chain of 311 word cells.
// ----------------------------------------------------------------------------
// Generate and write items are taken one per cycle unless the chain is
// rotating or the output is stalled; a generate result appears in the output
// register the cycle after its item is accepted. The ring position is held as
// the physical rotation of the cell chain, so a position item from p to n
// rotates the chain one cell per cycle until it reaches n, taking no item
// meanwhile. The state must be loaded by write items before generating.
module melg_random_generator_64 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_req_type,
    input  logic [8:0]          i_word_index,
    input  logic [63:0]         i_word_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [63:0]         o_random_value,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [63:0]         i_cfg_data
);

    melg_pkg::t_word      r_twist;
    melg_pkg::t_word      r_lag, n_lag;
    melg_pkg::t_idx       r_pos, n_pos;
    melg_pkg::t_idx       r_rot_cnt, n_rot_cnt;
    logic                 r_out_valid;
    melg_pkg::t_word      r_out_data;

    melg_pkg::t_ring_ctrl w_ctrl;
    melg_pkg::t_ring_taps w_taps;
    melg_pkg::t_req       w_req;
    melg_pkg::t_idx       w_pos_inc;
    melg_pkg::t_word      w_x, w_lag_new, w_new_word, w_result;
    logic                 w_accept, w_gen, w_rotating;

    assign w_req      = melg_pkg::t_req'(i_req_type);
    assign w_rotating = (r_rot_cnt != '0);
    assign o_in_ready = !w_rotating && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_gen      = w_accept && (w_req == melg_pkg::REQ_GENERATE);
    assign w_pos_inc  = (r_pos == melg_pkg::LAST_POS) ? '0 : r_pos + 1'b1;

    assign w_x = (w_taps.tap_p & melg_pkg::UPPER_BITS)
               | (w_taps.tap_q & melg_pkg::LOWER_BITS);
    assign w_lag_new = (w_x >> 1) ^ (w_x[0] ? r_twist : '0) ^ w_taps.tap_far
                     ^ r_lag ^ (r_lag << melg_pkg::LAG_SHIFT_L);
    assign w_new_word = w_x ^ w_lag_new ^ (w_lag_new >> melg_pkg::LAG_SHIFT_R);
    assign w_result = w_new_word ^ (w_new_word << melg_pkg::TEMPER_SHIFT)
                    ^ (w_taps.tap_temper & melg_pkg::TEMPER_MASK);

    assign w_ctrl.gen       = w_gen;
    assign w_ctrl.rotate    = w_rotating;
    assign w_ctrl.wr_en     = w_accept && (w_req == melg_pkg::REQ_WRITE)
                            && (i_word_index < melg_pkg::LAG_INDEX);
    assign w_ctrl.wr_offset = melg_pkg::ring_offset(i_word_index, r_pos);
    assign w_ctrl.wr_data   = i_word_value;
    assign w_ctrl.new_word  = w_new_word;

    melg_ring u_ring (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .o_taps (w_taps)
    );

    always_comb begin
        n_lag     = r_lag;
        n_pos     = r_pos;
        n_rot_cnt = r_rot_cnt;
        if (w_rotating) begin
            n_pos     = w_pos_inc;
            n_rot_cnt = r_rot_cnt - 1'b1;
        end else if (w_accept) begin
            unique case (i_req_type)
                melg_pkg::REQ_GENERATE: begin
                    n_lag = w_lag_new;
                    n_pos = w_pos_inc;
                end
                melg_pkg::REQ_WRITE: begin
                    if (i_word_index == melg_pkg::LAG_INDEX) begin
                        n_lag = i_word_value;
                    end
                end
                melg_pkg::REQ_POSITION: begin
                    if (i_word_index < melg_pkg::LAG_INDEX) begin
                        n_rot_cnt = melg_pkg::ring_offset(i_word_index, r_pos);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_twist     <= melg_pkg::TWIST_RESET;
            r_pos       <= '0;
            r_rot_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_twist <= i_cfg_data;
            end
            r_pos     <= n_pos;
            r_rot_cnt <= n_rot_cnt;
            if (w_gen) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lag <= n_lag;
        if (w_gen) begin
            r_out_data <= w_result;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out_data;

endmodule

// ===== tb/tb_melg_random_generator_64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_melg_random_generator_64
// Self-checking testbench for the MELG19937-64 random generator.
// ----------------------------------------------------------------------------
// The whole state is loaded by write items first, so no generate ever reads a
// word that was never written. Four phases then run under four twist matrix
// values and three handshake pacing modes. Each phase mixes generate bursts,
// state writes, ring position moves and requests the block must ignore. A
// software copy of the generator predicts every output word, and the outputs
// are compared in order.
// ----------------------------------------------------------------------------
module tb_melg_random_generator_64;

    localparam int         CLK_HALF_NS   = 5;
    localparam int         RESET_CYCLES  = 3;
    localparam int         SETTLE_CYCLES = 330;
    localparam int         STALL_CYCLES  = 200;
    localparam int         STALL_AFTER   = 60;
    localparam int         PHASE_ITEMS   = 365;
    localparam int         NUM_PHASES    = 4;
    localparam int         IDX_MAX       = (1 << melg_pkg::IDX_W) - 1;
    localparam longint     TIMEOUT_NS    = 20_000_000;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;

    class melg_tracker;
        melg_pkg::t_word ring_words[melg_pkg::RING_LEN];
        melg_pkg::t_word lag_word;
        int              position;
        melg_pkg::t_word twist;
        melg_pkg::t_word pending_values[$];
        int              mismatches;
        int              matched;

        function new();
            foreach (ring_words[i]) ring_words[i] = '0;
            lag_word   = '0;
            position   = 0;
            twist      = melg_pkg::TWIST_RESET;
            mismatches = 0;
            matched    = 0;
        endfunction

        function void take_request(logic [1:0] req, melg_pkg::t_idx idx,
                                   melg_pkg::t_word val);
            int              p;
            int              q;
            melg_pkg::t_word x;
            melg_pkg::t_word mixed;
            melg_pkg::t_word w;
            case (req)
                melg_pkg::REQ_GENERATE: begin
                    p = position;
                    q = (p + 1) % melg_pkg::RING_LEN;
                    x = (ring_words[p] & melg_pkg::UPPER_BITS)
                      | (ring_words[q] & melg_pkg::LOWER_BITS);
                    mixed = (x >> 1) ^ (x[0] ? twist : melg_pkg::t_word'(0))
                          ^ ring_words[(p + melg_pkg::FAR_OFFSET) % melg_pkg::RING_LEN]
                          ^ lag_word ^ (lag_word << melg_pkg::LAG_SHIFT_L);
                    lag_word = mixed;
                    w = x ^ mixed ^ (mixed >> melg_pkg::LAG_SHIFT_R);
                    ring_words[p] = w;
                    position = q;
                    pending_values.push_back(w ^ (w << melg_pkg::TEMPER_SHIFT)
                        ^ (ring_words[(p + melg_pkg::TEMPER_OFFSET) % melg_pkg::RING_LEN]
                           & melg_pkg::TEMPER_MASK));
                end
                melg_pkg::REQ_WRITE: begin
                    if (idx < melg_pkg::RING_LEN) begin
                        ring_words[idx] = val;
                    end else if (idx == melg_pkg::LAG_INDEX) begin
                        lag_word = val;
                    end
                end
                melg_pkg::REQ_POSITION: begin
                    if (idx < melg_pkg::RING_LEN) begin
                        position = int'(idx);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task match_output(melg_pkg::t_word got);
            melg_pkg::t_word want;
            if (pending_values.size() == 0) begin
                report_mismatch($sformatf("random_value %h with no generate pending", got));
            end else begin
                want = pending_values.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("random_value %h, expected %h", got, want));
                end else begin
                    matched++;
                end
            end
        endtask
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type     = melg_pkg::REQ_GENERATE;
    logic [8:0]  i_word_index   = '0;
    logic [63:0] i_word_value   = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [63:0] o_random_value;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data     = '0;

    melg_tracker tracker;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          stall_armed   = 1'b0;
    bit          stall_taken   = 1'b0;
    int          stall_left    = 0;

    melg_random_generator_64 DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_word_index   (i_word_index),
        .i_word_value   (i_word_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_random_value (o_random_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (stall_armed && !stall_taken) begin
            i_out_ready <= 1'b0;
            stall_left  <= STALL_CYCLES;
            stall_taken <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.match_output(o_random_value);
        end
    end

    function automatic melg_pkg::t_word rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic send_item(input logic [1:0] req, input melg_pkg::t_idx idx,
                             input melg_pkg::t_word val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_word_index <= idx;
        i_word_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.take_request(req, idx, val);
    endtask

    task automatic write_twist(input melg_pkg::t_word value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tracker.twist = value;
    endtask

    task automatic settle();
        while (tracker.pending_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int target, input bit with_stall);
        int             done_items;
        int             pick;
        int             burst;
        melg_pkg::t_idx idx;
        done_items = 0;
        while (done_items < target) begin
            if (with_stall && done_items >= STALL_AFTER) begin
                stall_armed <= 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 62) begin
                send_item(melg_pkg::REQ_GENERATE, melg_pkg::t_idx'($urandom()),
                          rand_word());
                done_items++;
            end else if (pick < 74) begin
                if ($urandom_range(4) == 0) begin
                    idx = melg_pkg::t_idx'($urandom_range(melg_pkg::RING_LEN + 1, IDX_MAX));
                end else begin
                    idx = melg_pkg::t_idx'($urandom_range(0, melg_pkg::RING_LEN));
                end
                send_item(melg_pkg::REQ_WRITE, idx, rand_word());
                done_items++;
            end else if (pick < 84) begin
                if ($urandom_range(4) == 0) begin
                    idx = melg_pkg::t_idx'($urandom_range(melg_pkg::RING_LEN, IDX_MAX));
                end else begin
                    idx = melg_pkg::t_idx'($urandom_range(0, melg_pkg::RING_LEN - 1));
                end
                send_item(melg_pkg::REQ_POSITION, idx, rand_word());
                done_items++;
            end else if (pick < 94) begin
                send_item(melg_pkg::REQ_POSITION,
                          melg_pkg::t_idx'($urandom_range(melg_pkg::RING_LEN - 12,
                                                          melg_pkg::RING_LEN - 1)),
                          rand_word());
                burst = $urandom_range(5, 24);
                repeat (burst) begin
                    send_item(melg_pkg::REQ_GENERATE, melg_pkg::t_idx'($urandom()),
                              rand_word());
                end
                done_items += burst + 1;
            end else begin
                send_item(REQ_UNUSED, melg_pkg::t_idx'($urandom()), rand_word());
                done_items++;
            end
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        melg_pkg::t_word twist_settings[NUM_PHASES];
        int              phase;
        tracker = new();
        twist_settings[0] = melg_pkg::TWIST_RESET;
        twist_settings[1] = '0;
        twist_settings[2] = '1;
        twist_settings[3] = {$urandom(), $urandom()};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                settle();
            end
            write_twist(twist_settings[phase]);
            case (phase)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0) begin
                for (int i = 0; i <= melg_pkg::RING_LEN; i++) begin
                    send_item(melg_pkg::REQ_WRITE, melg_pkg::t_idx'(i), rand_word());
                end
                send_item(melg_pkg::REQ_WRITE, melg_pkg::LAG_INDEX, '0);
                send_item(melg_pkg::REQ_WRITE, melg_pkg::t_idx'(0), '1);
                send_item(melg_pkg::REQ_WRITE, melg_pkg::t_idx'(1), '1);
                send_item(melg_pkg::REQ_POSITION, melg_pkg::t_idx'(0), '0);
                send_item(melg_pkg::REQ_GENERATE, '0, '0);
                send_item(melg_pkg::REQ_WRITE, melg_pkg::t_idx'(2), '0);
                send_item(melg_pkg::REQ_GENERATE, '1, '1);
                send_item(melg_pkg::REQ_POSITION, melg_pkg::LAST_POS, '1);
                send_item(melg_pkg::REQ_GENERATE, '0, '0);
                send_item(melg_pkg::REQ_GENERATE, '1, '0);
                send_item(melg_pkg::REQ_POSITION,
                          melg_pkg::t_idx'(melg_pkg::RING_LEN - melg_pkg::FAR_OFFSET), '0);
                send_item(melg_pkg::REQ_GENERATE, '0, '1);
                send_item(melg_pkg::REQ_POSITION,
                          melg_pkg::t_idx'(melg_pkg::RING_LEN - melg_pkg::TEMPER_OFFSET), '0);
                send_item(melg_pkg::REQ_GENERATE, '0, '0);
                send_item(melg_pkg::REQ_WRITE, melg_pkg::LAG_INDEX, '1);
                send_item(melg_pkg::REQ_GENERATE, '0, '0);
                send_item(melg_pkg::REQ_WRITE, melg_pkg::t_idx'(melg_pkg::RING_LEN + 1), '1);
                send_item(melg_pkg::REQ_WRITE, melg_pkg::t_idx'(IDX_MAX), '0);
                send_item(melg_pkg::REQ_POSITION, melg_pkg::LAG_INDEX, '0);
                send_item(melg_pkg::REQ_POSITION, melg_pkg::t_idx'(IDX_MAX), '1);
                send_item(REQ_UNUSED, '1, '1);
                send_item(REQ_UNUSED, '0, '0);
                send_item(melg_pkg::REQ_GENERATE, '1, '1);
            end

            run_random(PHASE_ITEMS, phase == 2);
        end
        settle();

        $display("Checked %0d generate outputs under %0d twist matrix values %s",
                 tracker.matched, NUM_PHASES, "and three pacing modes,");
        $display("with state writes, position moves, ignored requests and a %0d-cycle %s",
                 STALL_CYCLES, "output stall.");
        if (tracker.mismatches == 0) begin
            $display("melg_random_generator_64 verification clean");
        end else begin
            $display("melg_random_generator_64 verification failed");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("Timeout: %0d outputs still pending", tracker.pending_values.size());
        $display("melg_random_generator_64 verification failed");
        $finish;
    end

endmodule
